// ===== hw/rtl/ttb_pkg.sv =====
// Shared types and codes of the tick timer bank.
package ttb_pkg;

    // Action codes of an input word
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_ARM     = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // Configuration register indexes
    localparam logic REG_SHORT_PERIOD = 1'b0;
    localparam logic REG_LONG_PERIOD  = 1'b1;

    localparam logic [15:0] SHORT_PERIOD_RST = 16'd50;
    localparam logic [15:0] LONG_PERIOD_RST  = 16'd1000;

    // Width of an index into the timer bank, wide enough for banks of up to 64 timers
    localparam int IDX_EXT_W = 6;

    typedef enum logic [1:0] {
        TS_IDLE    = 2'd0,
        TS_RUNNING = 2'd1,
        TS_KICKED  = 2'd2,
        TS_ENDED   = 2'd3
    } tmr_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } ctl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic run_periodic;
        logic scan_step;
        logic apply;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_tick;
        logic scan_last;
    } ctl_sts_t;

endpackage

// ===== hw/rtl/tick_timer_bank.sv =====
// Top level of the tick timer bank: sequencer plus datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  input    | start, busy         | action, timer_index, load_value, with_callback
//  result   | done (1-cycle pulse)| short_event, long_event, kick_flag,
//           |                     | kicked_mask, ended_mask, addressed_state
//  config   | cfg_we              | cfg_index, cfg_data
//
// A word is taken at a clock edge with start high and busy low. A tick word
// goes through latch, countdown update, the bank scan and report; arm,
// release and the unused action go through latch, apply and report.
// The bank scan steps one timer per cycle through a single decrementer.
// done pulses for one cycle with the result word; the receiver
// cannot stall it. busy drops in the done cycle, so the next word can be taken
// then. Reset clears periods to 50 and 1000, reloads both countdowns and
// puts every timer idle with zero count and no callback.
module tick_timer_bank
    import ttb_pkg::*;
#(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [2:0]  timer_index,
    input  logic [15:0] load_value,
    input  logic        with_callback,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic        short_event,
    output logic        long_event,
    output logic        kick_flag,
    output logic [7:0]  kicked_mask,
    output logic [7:0]  ended_mask,
    output logic [1:0]  addressed_state
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // Sequence each word through execute, scan (tick words only) and report
    ttb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold countdowns, timer bank and the result word
    ttb_datapath #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .action          (action),
        .timer_index     (timer_index),
        .load_value      (load_value),
        .with_callback   (with_callback),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .short_event     (short_event),
        .long_event      (long_event),
        .kick_flag       (kick_flag),
        .kicked_mask     (kicked_mask),
        .ended_mask      (ended_mask),
        .addressed_state (addressed_state)
    );

    // A result pulse only ever follows a busy cycle and leaves the block free
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result pulse without a word in flight");

    // An accepted word always makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    // A timer cannot both kick and end on the same tick
    a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((kicked_mask & ended_mask) == 8'd0))
        else $error("timer reported both kicked and ended");

    // Any kicked timer raises the kick flag
    a_kick_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kicked_mask != 8'd0) |-> kick_flag)
        else $error("kicked timer without kick flag");

endmodule

// ===== hw/rtl/ttb_ctrl.sv =====
// Sequencer of the tick timer bank: accept, execute, scan, report.
module ttb_ctrl
    import ttb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd,
    output logic     busy
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.is_tick)
                begin
                    cmd.run_periodic = 1'b1;
                    state_next       = ST_SCAN;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/ttb_datapath.sv =====
// Datapath of the tick timer bank: periodic countdowns, timer bank, result word.
module ttb_datapath
    import ttb_pkg::*;
#(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    cmd,
    output ctl_sts_t    sts,
    input  logic [1:0]  action,
    input  logic [2:0]  timer_index,
    input  logic [15:0] load_value,
    input  logic        with_callback,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic        short_event,
    output logic        long_event,
    output logic        kick_flag,
    output logic [7:0]  kicked_mask,
    output logic [7:0]  ended_mask,
    output logic [1:0]  addressed_state
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Latched input word
    logic [1:0]  action_reg;
    logic [2:0]  idx_reg;
    logic [15:0] load_reg;
    logic        cb_reg;

    logic [15:0] short_period_reg;
    logic [15:0] long_period_reg;
    logic [15:0] short_cd_reg;
    logic [15:0] long_cd_reg;

    logic [COUNT_WIDTH-1:0] count_reg [NUM_TIMERS];
    tmr_state_t             tstate_reg [NUM_TIMERS];
    logic                   cb_bank_reg [NUM_TIMERS];

    logic [IDX_W-1:0] scan_reg;

    // Accumulated result of the current word
    logic       se_acc_reg;
    logic       le_acc_reg;
    logic       kick_acc_reg;
    logic [7:0] kmask_acc_reg;
    logic [7:0] emask_acc_reg;

    logic [IDX_EXT_W-1:0]   idx_ext;
    logic [IDX_W-1:0]       sel;
    logic                   sel_valid;
    logic [IDX_EXT_W-1:0]   scan_ext;
    logic [COUNT_WIDTH-1:0] scan_dec;
    logic [15:0]            short_dec;
    logic [15:0]            long_dec;

    assign idx_ext   = IDX_EXT_W'(idx_reg);
    assign sel       = idx_ext[IDX_W-1:0];
    assign sel_valid = (idx_ext < IDX_EXT_W'(NUM_TIMERS));
    assign scan_ext  = IDX_EXT_W'(scan_reg);
    assign scan_dec  = count_reg[scan_reg] - COUNT_WIDTH'(1);
    assign short_dec = short_cd_reg - 16'd1;
    assign long_dec  = long_cd_reg - 16'd1;

    assign sts.is_tick   = (action_reg == ACT_TICK);
    assign sts.scan_last = (scan_ext == IDX_EXT_W'(NUM_TIMERS - 1));

    // Configuration and periodic countdowns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_period_reg <= SHORT_PERIOD_RST;
            long_period_reg  <= LONG_PERIOD_RST;
            short_cd_reg     <= SHORT_PERIOD_RST;
            long_cd_reg      <= LONG_PERIOD_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SHORT_PERIOD)
                begin
                    short_period_reg <= cfg_data;
                end
                else
                begin
                    long_period_reg <= cfg_data;
                end
            end
            if (cmd.run_periodic)
            begin
                short_cd_reg <= (short_dec == 16'd0) ? short_period_reg : short_dec;
                long_cd_reg  <= (long_dec == 16'd0) ? long_period_reg : long_dec;
            end
        end
    end

    // Input latch, scan index and result accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= '0;
            se_acc_reg    <= 1'b0;
            le_acc_reg    <= 1'b0;
            kick_acc_reg  <= 1'b0;
            kmask_acc_reg <= '0;
            emask_acc_reg <= '0;
        end
        else if (cmd.latch)
        begin
            scan_reg      <= '0;
            se_acc_reg    <= 1'b0;
            le_acc_reg    <= 1'b0;
            kick_acc_reg  <= 1'b0;
            kmask_acc_reg <= '0;
            emask_acc_reg <= '0;
        end
        else
        begin
            if (cmd.run_periodic)
            begin
                se_acc_reg <= (short_dec == 16'd0);
                le_acc_reg <= (long_dec == 16'd0);
            end
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + IDX_W'(1);
                if (tstate_reg[scan_reg] == TS_RUNNING && scan_dec == '0)
                begin
                    if (cb_bank_reg[scan_reg])
                    begin
                        kick_acc_reg <= 1'b1;
                        if (scan_ext < IDX_EXT_W'(8))
                        begin
                            kmask_acc_reg[scan_ext[2:0]] <= 1'b1;
                        end
                    end
                    else if (scan_ext < IDX_EXT_W'(8))
                    begin
                        emask_acc_reg[scan_ext[2:0]] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= action;
            idx_reg    <= timer_index;
            load_reg   <= load_value;
            cb_reg     <= with_callback;
        end
    end

    // Timer bank: one entry per scan step, or the addressed entry on arm/release
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]   <= '0;
                tstate_reg[i]  <= TS_IDLE;
                cb_bank_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.scan_step && tstate_reg[scan_reg] == TS_RUNNING)
            begin
                count_reg[scan_reg] <= scan_dec;
                if (scan_dec == '0)
                begin
                    tstate_reg[scan_reg] <= cb_bank_reg[scan_reg] ? TS_KICKED : TS_ENDED;
                end
            end
            if (cmd.apply && sel_valid)
            begin
                if (action_reg == ACT_ARM)
                begin
                    count_reg[sel]   <= COUNT_WIDTH'(load_reg);
                    cb_bank_reg[sel] <= cb_reg;
                    tstate_reg[sel]  <= TS_RUNNING;
                end
                else if (action_reg == ACT_RELEASE)
                begin
                    tstate_reg[sel] <= TS_IDLE;
                end
            end
        end
    end

    // Result word: done strobe and payload registers, loaded at report; the payload holds until the next report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            short_event     <= se_acc_reg;
            long_event      <= le_acc_reg;
            kick_flag       <= kick_acc_reg;
            kicked_mask     <= kmask_acc_reg;
            ended_mask      <= emask_acc_reg;
            addressed_state <= sel_valid ? tstate_reg[sel] : TS_IDLE;
        end
    end

endmodule
